FILE: rtl/core/frpg_pkg.sv
// ----------------------------------------------------------------------------
// frpg_pkg
// Shared widths, register map and types of the first-touch page generator.
// ----------------------------------------------------------------------------
package frpg_pkg;

    // Scrambled unit numbers, pages and the Mersenne prime 2^19 - 1
    localparam int IDX_W  = 19;
    localparam logic [IDX_W-1:0] PRIME_MOD = {IDX_W{1'b1}};

    // Page size register and byte offset
    localparam int SIZE_W = 20;
    localparam int OFF_W  = 31;

    // Touched map: one bit per page, kept in rows of 32 bits
    localparam int ROW_W     = 32;
    localparam int BIT_AW    = 5;
    localparam int ROW_AW    = IDX_W - BIT_AW;
    localparam int MAP_ROWS  = 1 << ROW_AW;

    // Configuration register map
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam logic [1:0] REG_PAGE_UNITS    = 2'd0;
    localparam logic [1:0] REG_SCRAMBLE_SEED = 2'd1;
    localparam logic [1:0] REG_WRITE_MODE    = 2'd2;

    localparam logic [SIZE_W-1:0] PAGE_UNITS_RST    = SIZE_W'(1);
    localparam logic [IDX_W-1:0]  SCRAMBLE_SEED_RST = IDX_W'(13877);

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
    } div_status_t;

endpackage

FILE: rtl/core/frpg_sqmod.sv
// ----------------------------------------------------------------------------
// frpg_sqmod
// Shared square-and-reduce unit: registers x*x, then folds it modulo
// 2^19 - 1 and reflects the residue when bit 18 of x was set.
// ----------------------------------------------------------------------------
module frpg_sqmod
(
    input  logic                      clk,
    input  logic                      load,
    input  logic [frpg_pkg::IDX_W-1:0] operand,
    output logic [frpg_pkg::IDX_W-1:0] result
);
    import frpg_pkg::*;

    logic [2*IDX_W-1:0] prod_reg;
    logic               reflect_reg;
    logic [IDX_W:0]     fold1;
    logic [IDX_W-1:0]   fold2;
    logic [IDX_W-1:0]   resid;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg    <= operand * operand;
            reflect_reg <= operand[IDX_W-1];
        end
    end

    // Mersenne fold: 2^19 = 1 mod P
    always_comb
    begin
        fold1  = {1'b0, prod_reg[IDX_W-1:0]} + {1'b0, prod_reg[2*IDX_W-1:IDX_W]};
        fold2  = fold1[IDX_W-1:0] + {{(IDX_W-1){1'b0}}, fold1[IDX_W]};
        resid  = (fold2 == PRIME_MOD) ? '0 : fold2;
        result = reflect_reg ? (PRIME_MOD - resid) : resid;
    end

endmodule

FILE: rtl/core/frpg_div.sv
// ----------------------------------------------------------------------------
// frpg_div
// Restoring divider, one quotient bit per cycle, for unit / page size.
// ----------------------------------------------------------------------------
module frpg_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [frpg_pkg::IDX_W-1:0]  dividend,
    input  logic [frpg_pkg::SIZE_W-1:0] divisor,
    output logic [frpg_pkg::IDX_W-1:0]  quotient,
    output logic [frpg_pkg::IDX_W-1:0]  remainder,
    output frpg_pkg::div_status_t       status
);
    import frpg_pkg::*;

    localparam int CNT_W = $clog2(IDX_W + 1);

    logic [IDX_W-1:0]  quo_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [SIZE_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [SIZE_W-1:0] trial;
    logic [SIZE_W:0]   diff;
    logic              fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[IDX_W-1]};
        diff  = {1'b0, trial} - {1'b0, dvs_reg};
        fits  = !diff[SIZE_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(IDX_W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            busy_reg <= (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            // zero page size counts as one
            dvs_reg <= (divisor == '0) ? SIZE_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[IDX_W-2:0], fits};
            rem_reg <= fits ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
        end
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;

endmodule

FILE: rtl/core/frpg_map.sv
// ----------------------------------------------------------------------------
// frpg_map
// Touched-page bitmap in a 16384 x 32 memory with read-modify-write marking
// and a clearing pass of one row per cycle after reset.
// ----------------------------------------------------------------------------
module frpg_map
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       lookup,
    input  logic                       mark,
    input  logic [frpg_pkg::IDX_W-1:0] page,
    output logic                       ready,
    output logic                       first
);
    import frpg_pkg::*;

    logic [ROW_W-1:0]  mem [MAP_ROWS];
    logic [ROW_AW:0]   clr_cnt_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_AW-1:0] row_addr_reg;
    logic [BIT_AW-1:0] bit_reg;
    logic [ROW_W-1:0]  bit_mask;

    assign ready    = clr_cnt_reg[ROW_AW];
    assign bit_mask = ROW_W'(1) << bit_reg;
    assign first    = !row_reg[bit_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (!clr_cnt_reg[ROW_AW])
        begin
            clr_cnt_reg <= clr_cnt_reg + (ROW_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clr_cnt_reg[ROW_AW])
        begin
            mem[clr_cnt_reg[ROW_AW-1:0]] <= '0;
        end
        else if (mark)
        begin
            mem[row_addr_reg] <= row_reg | bit_mask;
        end
        if (lookup)
        begin
            row_reg      <= mem[page[IDX_W-1:BIT_AW]];
            row_addr_reg <= page[IDX_W-1:BIT_AW];
            bit_reg      <= page[BIT_AW-1:0];
        end
    end

endmodule

FILE: rtl/core/first_touch_random_page_generator.sv
// ----------------------------------------------------------------------------
// first_touch_random_page_generator
// Scrambles a sequence index with two quadratic-residue passes, divides the
// unit by the page size and reports page, byte offset and first visit.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   in      | sink      | in_valid/in_stall  | seq_index
//   out     | source    | out_valid/out_stall| page_number, byte_offset,
//           |           |                    | first_touch, write_request
//   cfg     | sink      | APB, pready = 1    | page_units, seed, write_mode
//
// Each item runs through S_RED1, S_SQ2 and S_RED2 for the two
// square-and-reduce passes, S_DIVGO and S_DIV in the bit-serial divider
// (one step per quotient bit), S_MRD and S_MWR for the bitmap
// read-modify-write and S_DONE to load the output register. A new transfer
// is taken only in S_IDLE, once the last item is through. After reset the
// bitmap clears one row per cycle: in_stall stays high through the clearing
// pass and the exit from the clear state. A held result does not block the
// next transfer; the item after it waits in S_DONE for a free output register.
// ----------------------------------------------------------------------------
module first_touch_random_page_generator
#(
    parameter int LOG2_UNIT_BYTES = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [frpg_pkg::ADDR_W-1:0]  paddr,
    input  logic [frpg_pkg::DATA_W-1:0]  pwdata,
    output logic [frpg_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [frpg_pkg::IDX_W-1:0]   seq_index,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [frpg_pkg::IDX_W-1:0]   page_number,
    output logic [frpg_pkg::OFF_W-1:0]   byte_offset,
    output logic                         first_touch,
    output logic                         write_request
);
    import frpg_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RED1   = 4'd2;
    localparam logic [3:0] S_SQ2    = 4'd3;
    localparam logic [3:0] S_RED2   = 4'd4;
    localparam logic [3:0] S_DIVGO  = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_MRD    = 4'd7;
    localparam logic [3:0] S_MWR    = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    localparam int EXT_W = OFF_W + IDX_W + LOG2_UNIT_BYTES;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [SIZE_W-1:0] page_units_reg;
    logic [IDX_W-1:0]  seed_reg;
    logic              write_mode_reg;
    logic [IDX_W-1:0]  x2_reg;
    logic [IDX_W-1:0]  unit_reg;
    logic              first_reg;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  page_reg;
    logic [OFF_W-1:0]  offset_reg;
    logic              first_out_reg;
    logic              wreq_reg;

    logic              cfg_wr;
    logic              in_xfer;
    logic              sq_load;
    logic [IDX_W-1:0]  sq_operand;
    logic [IDX_W-1:0]  sq_result;
    logic [IDX_W-1:0]  quotient;
    logic [IDX_W-1:0]  remainder;
    div_status_t       div_stat;
    logic              map_ready;
    logic              map_first;
    logic [IDX_W-1:0]  span;
    logic [EXT_W-1:0]  span_ext;
    logic              out_free;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_units_reg <= PAGE_UNITS_RST;
            seed_reg       <= SCRAMBLE_SEED_RST;
            write_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_PAGE_UNITS:    page_units_reg <= pwdata[SIZE_W-1:0];
                REG_SCRAMBLE_SEED: seed_reg       <= pwdata[IDX_W-1:0];
                REG_WRITE_MODE:    write_mode_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PAGE_UNITS:    prdata = DATA_W'(page_units_reg);
            REG_SCRAMBLE_SEED: prdata = DATA_W'(seed_reg);
            REG_WRITE_MODE:    prdata = DATA_W'(write_mode_reg);
            default:           prdata = '0;
        endcase
    end

    // Shared square-and-reduce unit, first pass on the transfer edge
    assign sq_load    = in_xfer || (state_reg == S_SQ2);
    assign sq_operand = (state_reg == S_IDLE) ? seq_index : x2_reg;

    frpg_sqmod u_sqmod
    (
        .clk     (clk),
        .load    (sq_load),
        .operand (sq_operand),
        .result  (sq_result)
    );

    frpg_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == S_DIVGO),
        .dividend  (unit_reg),
        .divisor   (page_units_reg),
        .quotient  (quotient),
        .remainder (remainder),
        .status    (div_stat)
    );

    frpg_map u_map
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .lookup (state_reg == S_MRD),
        .mark   (state_reg == S_MWR),
        .page   (quotient),
        .ready  (map_ready),
        .first  (map_first)
    );

    // page * size is the unit less the remainder
    assign span     = unit_reg - remainder;
    assign span_ext = {{OFF_W{1'b0}}, span, {LOG2_UNIT_BYTES{1'b0}}};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (map_ready) state_next = S_IDLE;
            S_IDLE:  if (in_valid) state_next = S_RED1;
            S_RED1:  state_next = S_SQ2;
            S_SQ2:   state_next = S_RED2;
            S_RED2:  state_next = S_DIVGO;
            S_DIVGO: state_next = S_DIV;
            S_DIV:   if (!div_stat.busy) state_next = S_MRD;
            S_MRD:   state_next = S_MWR;
            S_MWR:   state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RED1)
        begin
            x2_reg <= sq_result ^ seed_reg;
        end
        if (state_reg == S_RED2)
        begin
            unit_reg <= sq_result;
        end
        if (state_reg == S_MWR)
        begin
            first_reg <= map_first;
        end
        if (state_reg == S_DONE && out_free)
        begin
            page_reg      <= quotient;
            offset_reg    <= span_ext[OFF_W-1:0];
            first_out_reg <= first_reg;
            wreq_reg      <= write_mode_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign page_number   = page_reg;
    assign byte_offset   = offset_reg;
    assign first_touch   = first_out_reg;
    assign write_request = wreq_reg;

endmodule

FILE: rtl/core/frpg_checker.sv
// ----------------------------------------------------------------------------
// frpg_checker
// Port-level checks of the first-touch page generator, bound to the top.
// ----------------------------------------------------------------------------
module frpg_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [frpg_pkg::IDX_W-1:0]  page_number,
    input logic [frpg_pkg::OFF_W-1:0]  byte_offset,
    input logic                        first_touch
);
    import frpg_pkg::*;

    // a held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(page_number))
        else $error("result dropped or changed while stalled");

    a_out_first_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(first_touch) && $stable(byte_offset))
        else $error("first_touch or byte_offset changed while stalled");

    // one item at a time: busy right after each input transfer
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again before the item finished");

    // offsets are whole units of at least 512 bytes
    a_offset_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_offset[8:0] == 9'd0)
        else $error("byte_offset not unit aligned");

endmodule

bind first_touch_random_page_generator frpg_checker u_frpg_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .page_number (page_number),
    .byte_offset (byte_offset),
    .first_touch (first_touch)
);
